[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCCW_ASSERT_NEVER(lbl, expr, msg) \
  `TCCW_ASSERT(lbl, !(expr), msg)
`else
`define TCCW_ASSERT(lbl, prop, msg)
`define TCCW_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/tccw_pkg.sv]
// shared constants and control types for the text console writer
`timescale 1ns / 1ps
package tccw_pkg;
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic latch;
    logic put_update;
    logic clr_start;
    logic clr_step;
    logic emit_read;
    logic emit_put;
    logic emit_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic req_read;
    logic overflow;
    logic clr_last;
  } dp_status_t;
endpackage

[hw/rtl/tccw_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

[hw/rtl/tccw_dp.sv]
// datapath: cursor, attribute, clear sweep counter, screen store and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tccw_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tccw_pkg::dp_cmd_t              cmd,
  output tccw_pkg::dp_status_t           status,
  input  logic                           cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]    cfg_wr_data,
  input  logic                           in_req_type,
  input  logic [tccw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tccw_pkg::ADDR_W-1:0]    in_cell_address,
  output logic [tccw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tccw_pkg::CELL_W-1:0]    out_cell_value,
  output logic                           out_screen_cleared
);
  import tccw_pkg::*;

  localparam logic [ADDR_W:0] CELL_LIMIT = (ADDR_W+1)'(CELL_COUNT);

  logic [ATTR_W-1:0]  attr_r, clr_attr_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic               req_r;
  logic [CHAR_W-1:0]  char_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [CELL_AW-1:0] clr_cnt_r;

  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [CELL_W-1:0]  out_cell_r;
  logic               out_clr_r;

  logic [ROW_W-1:0]   row_nxt;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   wr_row;
  logic [COL_W-1:0]   wr_col;
  logic [CHAR_W-1:0]  wr_char;
  logic               put_we;
  logic [CELL_AW-1:0] put_addr;
  logic               addr_ok;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  // cursor movement and cell write for one put
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    wr_row  = row_r;
    wr_col  = col_r;
    wr_char = char_r;
    put_we  = 1'b0;
    if (char_r == CH_NEWLINE) begin
      row_nxt = row_r + 1'b1;
      col_nxt = '0;
    end else if (char_r == CH_BACKSPACE) begin
      if (col_r != '0) begin
        col_nxt = col_r - 1'b1;
        wr_col  = col_r - 1'b1;
        wr_char = CH_BLANK;
        put_we  = 1'b1;
      end else if (row_r != '0) begin
        row_nxt = row_r - 1'b1;
        col_nxt = COL_W'(COLUMNS - 1);
        wr_row  = row_r - 1'b1;
        wr_col  = COL_W'(COLUMNS - 1);
        wr_char = CH_BLANK;
        put_we  = 1'b1;
      end
    end else begin
      put_we = 1'b1;
      if (col_r == COL_W'(COLUMNS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign put_addr = CELL_AW'(CELL_AW'(wr_row) * CELL_AW'(COLUMNS)) + CELL_AW'(wr_col);
  assign addr_ok  = {1'b0, addr_r} < CELL_LIMIT;

  assign status.req_read = (req_r == REQ_READ);
  assign status.overflow = row_nxt >= ROW_W'(ROWS);
  assign status.clr_last = clr_cnt_r == CELL_AW'(CELL_COUNT - 1);

  assign ram_we    = cmd.clr_step | (cmd.put_update & put_we);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : put_addr;
  assign ram_wdata = cmd.clr_step ? {clr_attr_r, CH_BLANK} : {attr_r, wr_char};
  // out of range addresses read entry zero and get masked at the output
  assign ram_raddr = addr_ok ? addr_r[CELL_AW-1:0] : '0;

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r     <= ATTR_RESET;
      clr_attr_r <= ATTR_RESET;
      row_r      <= '0;
      col_r      <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (cmd.put_update) begin
        if (status.overflow) begin
          row_r <= '0;
          col_r <= '0;
        end else begin
          row_r <= row_nxt;
          col_r <= col_nxt;
        end
      end
      if (cmd.clr_start) begin
        clr_attr_r <= attr_r;
        clr_cnt_r  <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= status.clr_last ? '0 : clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      char_r <= in_char_code;
      addr_r <= in_cell_address;
    end
    if (cmd.emit_read) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_cell_r <= addr_ok ? ram_rdata : '0;
      out_clr_r  <= 1'b0;
    end else if (cmd.emit_put) begin
      out_row_r  <= row_nxt;
      out_col_r  <= col_nxt;
      out_cell_r <= '0;
      out_clr_r  <= 1'b0;
    end else if (cmd.emit_clear) begin
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_cell_r <= '0;
      out_clr_r  <= 1'b1;
    end
  end

  assign out_cursor_row     = out_row_r;
  assign out_cursor_col     = out_col_r;
  assign out_cell_value     = out_cell_r;
  assign out_screen_cleared = out_clr_r;

  `TCCW_ASSERT(a_cursor_in_range, (row_r < ROW_W'(ROWS)) && (col_r < COL_W'(COLUMNS)), "cursor out of screen")
  `TCCW_ASSERT_NEVER(a_put_during_clear, cmd.clr_step && cmd.put_update, "put while clearing")
  `TCCW_ASSERT(a_clear_starts_home, cmd.clr_start |=> (row_r == '0) && (col_r == '0) && (clr_cnt_r == '0), "clear did not home")
endmodule

[hw/rtl/tccw_ctrl.sv]
// controller state machine: request sequencing and screen clear sweep
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tccw_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  output logic                    out_valid,
  output tccw_pkg::dp_cmd_t       cmd,
  input  tccw_pkg::dp_status_t    status
);
  import tccw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_RDATA = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   report_r, report_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.req_read) begin
          state_nxt = S_RDATA;
        end else begin
          cmd.put_update = 1'b1;
          if (status.overflow) begin
            cmd.clr_start = 1'b1;
            report_nxt    = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            cmd.emit_put = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_RDATA: begin
        cmd.emit_read = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          // the sweep after reset reports nothing
          cmd.emit_clear = report_r;
          report_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      report_r    <= report_nxt;
      out_valid_r <= cmd.emit_read | cmd.emit_put | cmd.emit_clear;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `TCCW_ASSERT(a_single_strobe, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `TCCW_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `TCCW_ASSERT(a_clear_ends, (state_r == S_CLEAR) && status.clr_last |=> (state_r == S_IDLE), "clear sweep overran")
endmodule

[hw/rtl/text_console_cursor_writer.sv]
// top level of the text console writer: controller plus datapath
// a read item goes from S_EXEC through S_RDATA to its registered result, a put gives its result from S_EXEC;
//   a read goes through the single ram read port, a put through the cursor update logic; busy until the result
// a put that runs past the bottom row sweeps the 2000 cell store one cell a cycle,
//   result when the sweep ends, then the next item is taken
// after reset the same sweep writes blank cells, busy high until it ends, no result
// results are a one cycle strobe on out_valid and cannot be held off
`timescale 1ns / 1ps
module text_console_cursor_writer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [tccw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tccw_pkg::ADDR_W-1:0]    in_cell_address,
  output logic                           out_valid,
  output logic [tccw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tccw_pkg::CELL_W-1:0]    out_cell_value,
  output logic                           out_screen_cleared,
  input  logic                           cfg_wr_en,
  input  logic [tccw_pkg::ATTR_W-1:0]    cfg_wr_data
);
  import tccw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  tccw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_req_type        (in_req_type),
    .in_char_code       (in_char_code),
    .in_cell_address    (in_cell_address),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cell_value     (out_cell_value),
    .out_screen_cleared (out_screen_cleared)
  );
endmodule
